[rtl/core/lcgr_pkg.sv]
package lcgr_pkg;

   localparam logic [31:0] SEED_RESET = 32'h1de5_89c0;
   localparam logic [31:0] LCG_INC    = 32'h3141_5927;
   localparam int          DVD_W      = 24;

   localparam logic [2:0] KIND_ENTROPY = 3'd0;
   localparam logic [2:0] KIND_BYTE    = 3'd1;
   localparam logic [2:0] KIND_TWO     = 3'd2;
   localparam logic [2:0] KIND_THREE   = 3'd3;
   localparam logic [2:0] KIND_ONE     = 3'd4;
   localparam logic [2:0] KIND_MOD_OLD = 3'd5;
   localparam logic [2:0] KIND_MOD     = 3'd6;
   localparam logic [2:0] KIND_RANGE   = 3'd7;

   typedef enum logic [2:0] {
      SEL_CONST,
      SEL_BYTE,
      SEL_TWO,
      SEL_THREE,
      SEL_ONE,
      SEL_MOD_OLD,
      SEL_MOD
   } sel_type;

   typedef struct packed {
      logic [1:0]  steps;
      logic        has_result;
      sel_type     sel;
      logic [15:0] divisor;
      logic [15:0] addend;
   } cmd_type;

   // seed * 0x010101 + inc, mod 2^32
   function automatic logic [31:0] lcg_next(input logic [31:0] s);
      lcg_next = s + {s[23:0], 8'h00} + {s[15:0], 16'h0000} + LCG_INC;
   endfunction

endpackage

[rtl/core/lcg_random_with_ranges.sv]
// 32-bit linear congruential random source (seed * 0x010101 + 0x31415927) with
// range-limited request kinds. Requests enter a queue of QUEUE_DEPTH entries and
// are carried out one at a time by the back end, which holds the seed. The plain
// kinds and the entropy kind need only seed steps; the modulo and range kinds also
// run the 24-iteration restoring divider in the back end. A zero modulus or an
// empty range gives its answer without the divider. One finished result waits
// in the output register while the next request is worked on.
module lcg_random_with_ranges #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_joypad,
   input  logic [15:0] req_bound_max,
   input  logic [15:0] req_bound_min,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_value
);
   import lcgr_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_wr_cmd;
   cmd_type q_rd_cmd;

   lcgr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_joypad    (req_joypad),
      .req_bound_max (req_bound_max),
      .req_bound_min (req_bound_min),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_wr_cmd)
   );

   lcgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_cmd),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_cmd),
      .q_empty (q_empty)
   );

   lcgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (q_rd_cmd),
      .q_pop     (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_value (rsp_value)
   );

   a_accept_enqueues: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |-> (q_push && !q_full))
      else $error("accepted request not queued");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_rd_cmd.sel == SEL_MOD || q_rd_cmd.sel == SEL_MOD_OLD))
      |-> (q_rd_cmd.divisor != 16'd0))
      else $error("modulo request with zero divisor");

   a_entropy_steps: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_wr_cmd.has_result) |-> (q_wr_cmd.steps != 2'd0))
      else $error("entropy request without a seed step");

endmodule

[rtl/core/lcgr_front.sv]
module lcgr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [2:0]       req_kind,
   input  logic [15:0]      req_joypad,
   input  logic [15:0]      req_bound_max,
   input  logic [15:0]      req_bound_min,
   input  logic             q_full,
   output logic             q_push,
   output lcgr_pkg::cmd_type q_cmd
);
   import lcgr_pkg::*;

   logic [15:0] last_joypad_ff;
   logic [15:0] last_joypad_in;
   logic        joy_changed;
   logic [15:0] span;

   assign full        = q_full;
   assign q_push      = push && !q_full;
   assign joy_changed = req_joypad != last_joypad_ff;
   assign span        = req_bound_max - req_bound_min;

   always_comb begin
      q_cmd.steps      = 2'd1;
      q_cmd.has_result = 1'b1;
      q_cmd.sel        = SEL_CONST;
      q_cmd.divisor    = 16'd0;
      q_cmd.addend     = 16'd0;
      case (req_kind)
         KIND_ENTROPY: begin
            q_cmd.steps      = joy_changed ? 2'd2 : 2'd1;
            q_cmd.has_result = 1'b0;
         end
         KIND_BYTE:  q_cmd.sel = SEL_BYTE;
         KIND_TWO:   q_cmd.sel = SEL_TWO;
         KIND_THREE: q_cmd.sel = SEL_THREE;
         KIND_ONE:   q_cmd.sel = SEL_ONE;
         KIND_MOD_OLD: begin
            if (req_bound_max[7:0] == 8'd0) begin
               q_cmd.steps = 2'd0;
            end else begin
               q_cmd.sel     = SEL_MOD_OLD;
               q_cmd.divisor = {8'd0, req_bound_max[7:0]};
            end
         end
         KIND_MOD: begin
            if (req_bound_max == 16'd0) begin
               q_cmd.steps = 2'd0;
            end else begin
               q_cmd.sel     = SEL_MOD;
               q_cmd.divisor = req_bound_max;
            end
         end
         KIND_RANGE: begin
            q_cmd.addend = req_bound_min;
            if (req_bound_max <= req_bound_min) begin
               q_cmd.steps = 2'd0;
            end else begin
               q_cmd.sel     = SEL_MOD;
               q_cmd.divisor = span;
            end
         end
         default: q_cmd.steps = 2'd0;
      endcase
   end

   always_comb begin
      last_joypad_in = last_joypad_ff;
      if (q_push && req_kind == KIND_ENTROPY) begin
         last_joypad_in = req_joypad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_joypad_ff <= 16'd0;
      end else begin
         last_joypad_ff <= last_joypad_in;
      end
   end

endmodule

[rtl/core/lcgr_queue.sv]
module lcgr_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  lcgr_pkg::cmd_type wr_data,
   output logic             q_full,
   input  logic             rd_en,
   output lcgr_pkg::cmd_type rd_data,
   output logic             q_empty
);
   import lcgr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_wr;
   logic              do_rd;

   assign q_full  = count_ff == CNT_W'(DEPTH);
   assign q_empty = count_ff == CNT_W'(0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/lcgr_back.sv]
module lcgr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  lcgr_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             empty,
   input  logic             pop,
   output logic [15:0]      rsp_value
);
   import lcgr_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [31:0]       seed_ff;
   cmd_type           cmd_ff;
   logic [1:0]        steps_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [15:0]       rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_load;
   logic [15:0]       out_value_ff;

   logic [16:0]       trial;
   logic [16:0]       diff;
   logic [15:0]       rem_in;
   logic [1:0]        three_r;
   logic [15:0]       value_in;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign empty     = !out_valid_ff;
   assign rsp_value = out_value_ff;
   assign out_load  = (state_ff == ST_DONE) && (!out_valid_ff || pop);

   // one restoring divide step
   assign trial  = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff   = trial - {1'b0, cmd_ff.divisor};
   assign rem_in = diff[16] ? trial[15:0] : diff[15:0];

   always_comb begin
      three_r = seed_ff[1:0];
      if (three_r == 2'd0) begin
         three_r = (seed_ff[3:2] == 2'd0) ? 2'd2 : seed_ff[3:2];
      end
   end

   always_comb begin
      case (cmd_ff.sel)
         SEL_BYTE:    value_in = {8'd0, seed_ff[23:16]};
         SEL_TWO:     value_in = {14'd0, seed_ff[1:0]};
         SEL_THREE:   value_in = {14'd0, three_r - 2'd1};
         SEL_ONE:     value_in = {15'd0, seed_ff[16]};
         SEL_MOD_OLD: value_in = rem_ff + cmd_ff.addend;
         SEL_MOD:     value_in = rem_ff + cmd_ff.addend;
         default:     value_in = cmd_ff.addend;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  cmd_ff   <= q_cmd;
                  steps_ff <= q_cmd.steps;
                  dvd_ff   <= {8'd0, seed_ff[31:16]};
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (steps_ff != 2'd0) begin
                  seed_ff  <= lcg_next(seed_ff);
                  steps_ff <= steps_ff - 2'd1;
               end else if (cmd_ff.sel == SEL_MOD || cmd_ff.sel == SEL_MOD_OLD) begin
                  if (cmd_ff.sel == SEL_MOD) begin
                     dvd_ff <= {seed_ff[31:24], seed_ff[31:16]};
                  end
                  rem_ff   <= 16'd0;
                  cnt_ff   <= CNT_W'(DVD_W - 1);
                  state_ff <= ST_DIV;
               end else if (cmd_ff.has_result) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(0)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_load) begin
                  out_value_ff <= value_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[dv/lcg_value_checker.sv]
`timescale 1ns / 1ps

module lcg_value_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_joypad,
   input  logic [15:0] req_bound_max,
   input  logic [15:0] req_bound_min,
   input  logic        empty,
   input  logic        pop,
   input  logic [15:0] rsp_value,
   output int          mismatches,
   output int          outstanding,
   output int          values_checked
);
   import lcgr_pkg::*;

   localparam logic [31:0] SEED_MULT = 32'h0001_0101;

   logic [31:0] rng_seed;
   logic [15:0] last_pad;
   logic [15:0] expected_values[$];
   logic [15:0] exp_value;
   logic [15:0] new_value;
   bit          has_value;

   function automatic void seed_step();
      rng_seed = rng_seed * SEED_MULT + LCG_INC;
   endfunction

   function automatic logic [23:0] seed_slice();
      seed_slice = {rng_seed[31:24], rng_seed[31:16]};
   endfunction

   task automatic predict_request(input logic [2:0] kind, input logic [15:0] pad,
                                  input logic [15:0] bmax, input logic [15:0] bmin,
                                  output bit has_out, output logic [15:0] val);
      logic [15:0] dividend;
      logic [7:0]  modulus;
      logic [15:0] span;
      logic [1:0]  pick;
      has_out = 1'b1;
      val = 16'h0000;
      case (kind)
         KIND_ENTROPY: begin
            if (pad != last_pad) begin
               last_pad = pad;
               seed_step();
            end
            seed_step();
            has_out = 1'b0;
         end
         KIND_BYTE: begin
            seed_step();
            val = {8'h00, rng_seed[23:16]};
         end
         KIND_TWO: begin
            seed_step();
            val = {14'h0000, rng_seed[1:0]};
         end
         KIND_THREE: begin
            seed_step();
            pick = rng_seed[1:0];
            if (pick == 2'd0) begin
               pick = rng_seed[3:2];
               if (pick == 2'd0) pick = 2'd2;
            end
            val = {14'h0000, pick} - 16'd1;
         end
         KIND_ONE: begin
            seed_step();
            val = {15'h0000, rng_seed[16]};
         end
         KIND_MOD_OLD: begin
            modulus = bmax[7:0];
            if (modulus != 8'h00) begin
               dividend = rng_seed[31:16];
               seed_step();
               val = 16'(32'(dividend) % 32'(modulus));
            end
         end
         KIND_MOD: begin
            if (bmax != 16'h0000) begin
               seed_step();
               val = 16'(32'(seed_slice()) % 32'(bmax));
            end
         end
         KIND_RANGE: begin
            if (bmax <= bmin) begin
               val = bmin;
            end else begin
               span = bmax - bmin;
               seed_step();
               val = 16'(32'(seed_slice()) % 32'(span)) + bmin;
            end
         end
         default: has_out = 1'b0;
      endcase
   endtask

   initial begin
      mismatches = 0;
      outstanding = 0;
      values_checked = 0;
      rng_seed = SEED_RESET;
      last_pad = 16'h0000;
   end

   always @(posedge clock) begin
      if (reset) begin
         rng_seed = SEED_RESET;
         last_pad = 16'h0000;
         expected_values.delete();
      end else begin
         if (pop && !empty) begin
            if (expected_values.size() == 0) begin
               $display("%0t: value with no request waiting, got %h", $time, rsp_value);
               mismatches++;
            end else begin
               exp_value = expected_values.pop_front();
               values_checked++;
               if (rsp_value !== exp_value) begin
                  $display("%0t: value mismatch, expected %h, got %h",
                           $time, exp_value, rsp_value);
                  mismatches++;
               end
            end
         end
         if (push && !full) begin
            predict_request(req_kind, req_joypad, req_bound_max, req_bound_min,
                            has_value, new_value);
            if (has_value) expected_values.push_back(new_value);
         end
      end
      outstanding = expected_values.size();
   end

endmodule

[dv/tb_lcg_random_with_ranges.sv]
`timescale 1ns / 1ps

module tb_lcg_random_with_ranges;
   import lcgr_pkg::*;

   localparam int ITEMS_PER_PHASE = 475;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 40;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [2:0]  req_kind;
   logic [15:0] req_joypad;
   logic [15:0] req_bound_max;
   logic [15:0] req_bound_min;
   logic        empty;
   logic        pop;
   logic [15:0] rsp_value;

   int mismatches;
   int outstanding;
   int values_checked;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;
   int requests_sent;
   int entropy_sent;
   logic [15:0] prev_pad;

   lcg_random_with_ranges dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_joypad    (req_joypad),
      .req_bound_max (req_bound_max),
      .req_bound_min (req_bound_min),
      .empty         (empty),
      .pop           (pop),
      .rsp_value     (rsp_value)
   );

   lcg_value_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_joypad     (req_joypad),
      .req_bound_max  (req_bound_max),
      .req_bound_min  (req_bound_min),
      .empty          (empty),
      .pop            (pop),
      .rsp_value      (rsp_value),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .values_checked (values_checked)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side stalls
   always @(negedge clock) begin
      pop = ($urandom_range(99) >= recv_stall_pct);
   end

   // entered and left at a falling edge
   task automatic send_request(input logic [2:0] kind, input logic [15:0] pad,
                               input logic [15:0] bmax, input logic [15:0] bmin);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_kind = kind;
      req_joypad = pad;
      req_bound_max = bmax;
      req_bound_min = bmin;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      requests_sent++;
      if (kind == KIND_ENTROPY) entropy_sent++;
   endtask

   task automatic random_request();
      logic [2:0]  kind;
      logic [15:0] pad;
      logic [15:0] bmax;
      logic [15:0] bmin;
      int          pick;
      kind = 3'($urandom_range(7));
      pad = prev_pad;
      if ($urandom_range(3) == 0) pad = 16'($urandom);
      bmax = 16'($urandom);
      bmin = 16'($urandom);
      pick = $urandom_range(11);
      case (pick)
         0: bmax = 16'h0000;
         1: bmax = 16'hffff;
         2: bmin = 16'h0000;
         3: bmax[7:0] = 8'($urandom_range(1, 8));
         4: bmax = bmin;
         5: bmax = 16'($urandom_range(1, 20));
         default: ;
      endcase
      if (kind == KIND_RANGE && pick >= 6 && bmax < bmin) begin
         {bmax, bmin} = {bmin, bmax};
      end
      if (kind == KIND_ENTROPY) prev_pad = pad;
      send_request(kind, pad, bmax, bmin);
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_kind = KIND_ENTROPY;
      req_joypad = 16'h0000;
      req_bound_max = 16'h0000;
      req_bound_min = 16'h0000;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      requests_sent = 0;
      entropy_sent = 0;
      prev_pad = 16'h0000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every kind, bound extremes, zero modulus, empty range, entropy
      send_request(KIND_BYTE,    16'h0000, 16'h0000, 16'h0000);
      send_request(KIND_TWO,     16'h0000, 16'hffff, 16'hffff);
      send_request(KIND_THREE,   16'h0000, 16'h0000, 16'h0000);
      send_request(KIND_ONE,     16'h0000, 16'h0000, 16'h0000);
      send_request(KIND_ENTROPY, 16'h0000, 16'h0000, 16'h0000);
      send_request(KIND_ENTROPY, 16'hffff, 16'h0000, 16'h0000);
      send_request(KIND_ENTROPY, 16'hffff, 16'hffff, 16'hffff);
      send_request(KIND_ENTROPY, 16'h0000, 16'h0000, 16'h0000);
      send_request(KIND_MOD_OLD, 16'h0000, 16'hff00, 16'h0000);
      send_request(KIND_MOD_OLD, 16'h0000, 16'h00ff, 16'h0000);
      send_request(KIND_MOD_OLD, 16'h0000, 16'h0001, 16'h0000);
      send_request(KIND_MOD_OLD, 16'h0000, 16'hffff, 16'hffff);
      send_request(KIND_MOD,     16'h0000, 16'h0000, 16'h0000);
      send_request(KIND_MOD,     16'h0000, 16'h0001, 16'h0000);
      send_request(KIND_MOD,     16'h0000, 16'hffff, 16'h0000);
      send_request(KIND_MOD,     16'h0000, 16'h8000, 16'hffff);
      send_request(KIND_RANGE,   16'h0000, 16'h1234, 16'h1234);
      send_request(KIND_RANGE,   16'h0000, 16'h0000, 16'hffff);
      send_request(KIND_RANGE,   16'h0000, 16'hffff, 16'h0000);
      send_request(KIND_RANGE,   16'h0000, 16'hffff, 16'hfffe);
      send_request(KIND_RANGE,   16'h0000, 16'h0001, 16'h0000);
      send_request(KIND_RANGE,   16'h0000, 16'h0000, 16'h0000);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) random_request();
      end

      push = 1'b0;
      recv_stall_pct = 0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d requests (%0d entropy), checked %0d values", requests_sent,
               entropy_sent, values_checked);
      $display("pacing covered free flow, idle sender, stalled receiver and light mix");
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
